FILE: hw/rtl/usd_pkg.sv
`timescale 1ns / 1ps

package usd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned RunCntW = 3;   // up to four results per byte

  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContCode  = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;
  localparam logic [ByteW-1:0] AsciiMask = 8'h80;
  localparam logic [ByteW-1:0] ContBits  = 8'h3F;
  localparam logic [ByteW-1:0] Lead2Bits = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Bits = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Bits = 8'h07;

  // one byte's results: cnt-1 invalid zeros, then one final result
  typedef struct packed {
    logic [RunCntW-1:0] cnt;
    logic [CpW-1:0]     last_cp;
    logic               last_inv;
  } run_desc_t;

endpackage

FILE: hw/rtl/usd_decode.sv
`timescale 1ns / 1ps

module usd_decode import usd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             end_of_text_i,
  output run_desc_t        desc_o
);

  logic [CpW-1:0] pv_q, pv_d;
  logic [1:0]     need_q, need_d;
  logic [1:0]     held_q, held_d;

  logic           pending;
  logic           is_cont;
  logic [CpW-1:0] pv_shift;
  logic [1:0]     held_inc;
  logic [RunCntW-1:0] flush_cnt;

  assign pending  = (need_q != 2'd0);
  assign is_cont  = ((text_byte_i & ContMask) == ContCode);
  assign pv_shift = {pv_q[CpW-7:0], text_byte_i[5:0]};
  assign held_inc = held_q + 2'd1;

  always_comb begin
    pv_d           = pv_q;
    need_d         = need_q;
    held_d         = held_q;
    desc_o.cnt     = '0;
    desc_o.last_cp = '0;
    desc_o.last_inv = 1'b1;
    flush_cnt      = '0;
    if (pending && is_cont) begin
      if (need_q == 2'd1) begin
        desc_o.cnt      = RunCntW'(1);
        desc_o.last_cp  = pv_shift;
        desc_o.last_inv = 1'b0;
        pv_d   = '0;
        need_d = 2'd0;
        held_d = 2'd0;
      end else if (end_of_text_i) begin
        // truncated: lead, every held continuation and this continuation
        desc_o.cnt = RunCntW'(2) + RunCntW'(held_q);
        pv_d   = '0;
        need_d = 2'd0;
        held_d = 2'd0;
      end else begin
        pv_d   = pv_shift;
        need_d = need_q - 2'd1;
        held_d = held_inc;
      end
    end else begin
      if (pending) begin
        flush_cnt = RunCntW'(1) + RunCntW'(held_q);
      end
      pv_d   = '0;
      need_d = 2'd0;
      held_d = 2'd0;
      desc_o.cnt = flush_cnt;
      if ((text_byte_i & AsciiMask) == '0) begin
        desc_o.cnt      = flush_cnt + RunCntW'(1);
        desc_o.last_cp  = CpW'(text_byte_i);
        desc_o.last_inv = 1'b0;
      end else if ((text_byte_i & Lead2Mask) == Lead2Code ||
                   (text_byte_i & Lead3Mask) == Lead3Code ||
                   (text_byte_i & Lead4Mask) == Lead4Code) begin
        if (end_of_text_i) begin
          desc_o.cnt = flush_cnt + RunCntW'(1);
        end else if ((text_byte_i & Lead2Mask) == Lead2Code) begin
          pv_d   = CpW'(text_byte_i & Lead2Bits);
          need_d = 2'd1;
        end else if ((text_byte_i & Lead3Mask) == Lead3Code) begin
          pv_d   = CpW'(text_byte_i & Lead3Bits);
          need_d = 2'd2;
        end else begin
          pv_d   = CpW'(text_byte_i & Lead4Bits);
          need_d = 2'd3;
        end
      end else begin
        // stray continuation or F8-FF
        desc_o.cnt = flush_cnt + RunCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= '0;
      need_q <= 2'd0;
      held_q <= 2'd0;
    end else if (take_i) begin
      pv_q   <= pv_d;
      need_q <= need_d;
      held_q <= held_d;
    end
  end

  // held continuations never exceed what the lead asked for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q == 2'd0) |-> (held_q == 2'd0))
    else $error("held continuations with no sequence pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, need_q} + {1'b0, held_q}) <= 3'd3)
    else $error("sequence longer than four bytes");

endmodule

FILE: hw/rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// UTF-8 byte stream to code point decoder.
// Input channel: in_valid_i/in_ready_o carry text_byte_i and end_of_text_i,
// one byte per transaction. Output channel: out_valid_o/out_ready_i carry
// code_point_o, invalid_o and run_last_o, one result per transaction.
// A byte yields zero to four results; run_last_o marks the last result of a
// byte. Lead bytes of a multi-byte form yield nothing until the sequence
// completes or breaks; a broken or truncated sequence gives one invalid zero
// for the lead and for each held continuation before the breaking byte is
// decoded on its own.
// The first result of a byte is offered the cycle after the byte is taken if
// the output slot is free. Throughput: one byte per cycle while each byte
// yields at most one result and out_ready_i stays high.
// A two-entry run queue (one active run plus one waiting) sits between the
// decoder and the output, so a byte is taken while a result still waits.
// When the receiver stalls the queue fills and in_ready_o drops.
// Reset clears the pending sequence and empties the queue.
module utf8_stream_decoder import usd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             end_of_text_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CpW-1:0]   code_point_o,
  output logic             invalid_o,
  output logic             run_last_o
);

  run_desc_t new_desc;
  logic      take;
  logic      pop;
  logic      head_free;
  logic      new_nonzero;

  logic [RunCntW-1:0] h_rem_q, h_rem_d;
  logic [CpW-1:0]     h_cp_q, h_cp_d;
  logic               h_inv_q, h_inv_d;
  logic               t_valid_q, t_valid_d;
  run_desc_t          t_desc_q, t_desc_d;

  assign in_ready_o = !t_valid_q;
  assign take       = in_valid_i && in_ready_o;

  usd_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .desc_o        (new_desc)
  );

  assign new_nonzero = take && (new_desc.cnt != '0);

  assign out_valid_o  = (h_rem_q != '0);
  assign run_last_o   = (h_rem_q == RunCntW'(1));
  assign code_point_o = run_last_o ? h_cp_q : '0;
  assign invalid_o    = run_last_o ? h_inv_q : 1'b1;

  assign pop       = out_valid_o && out_ready_i;
  assign head_free = !out_valid_o || (pop && run_last_o);

  always_comb begin
    h_rem_d   = h_rem_q;
    h_cp_d    = h_cp_q;
    h_inv_d   = h_inv_q;
    t_valid_d = t_valid_q;
    t_desc_d  = t_desc_q;
    if (head_free) begin
      if (t_valid_q) begin
        h_rem_d   = t_desc_q.cnt;
        h_cp_d    = t_desc_q.last_cp;
        h_inv_d   = t_desc_q.last_inv;
        t_valid_d = 1'b0;
      end else if (new_nonzero) begin
        h_rem_d = new_desc.cnt;
        h_cp_d  = new_desc.last_cp;
        h_inv_d = new_desc.last_inv;
      end else begin
        h_rem_d = '0;
      end
    end else if (pop) begin
      h_rem_d = h_rem_q - RunCntW'(1);
    end
    // the tail only takes a run that cannot go straight to the head
    if (new_nonzero && (!head_free || t_valid_q)) begin
      t_valid_d = 1'b1;
      t_desc_d  = new_desc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_rem_q   <= '0;
      t_valid_q <= 1'b0;
    end else begin
      h_rem_q   <= h_rem_d;
      t_valid_q <= t_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_cp_q   <= h_cp_d;
    h_inv_q  <= h_inv_d;
    t_desc_q <= t_desc_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_valid_q |-> (h_rem_q != '0))
    else $error("waiting run with an empty output slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_rem_q <= RunCntW'(4))
    else $error("run longer than four results");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !run_last_o) |=> (h_rem_q == $past(h_rem_q) - RunCntW'(1)))
    else $error("run count did not step down on a taken result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_last_o) |-> (invalid_o && (code_point_o == '0)))
    else $error("non-final result of a run is not an invalid zero");

endmodule

FILE: test/utf8_stream_decoder_tb.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
  import usd_pkg::*;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned RandItems   = 250;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned HoldAtCount = 30;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned TimeoutNs   = 2_000_000;
  localparam int unsigned DirRows     = 28;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           invalid;
    logic           run_last;
  } cp_result_t;

  // typed rows: n results, n-1 invalid zeros and then last_cp / last_inv
  typedef struct packed {
    logic [ByteW-1:0]   tbyte;
    logic               eot;
    logic               typed;
    logic [RunCntW-1:0] n;
    logic [CpW-1:0]     last_cp;
    logic               last_inv;
  } dir_row_t;

  localparam dir_row_t DirTab [DirRows] = '{
    '{8'h00, 1'b0, 1'b1, 3'd1, 21'h000000, 1'b0},  // byte zero is plain ascii
    '{8'h7F, 1'b0, 1'b1, 3'd1, 21'h00007F, 1'b0},
    '{8'h80, 1'b0, 1'b1, 3'd1, 21'h000000, 1'b1},  // stray continuation
    '{8'hF8, 1'b0, 1'b1, 3'd1, 21'h000000, 1'b1},  // bad lead
    '{8'hFF, 1'b0, 1'b1, 3'd1, 21'h000000, 1'b1},
    '{8'hC2, 1'b0, 1'b1, 3'd0, 21'h000000, 1'b0},
    '{8'hA9, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'hE2, 1'b0, 1'b1, 3'd0, 21'h000000, 1'b0},
    '{8'h82, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'hAC, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'h9F, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'h98, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'hF7, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},  // top 4-byte lead
    '{8'hBF, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'hBF, 1'b0, 1'b1, 3'd1, 21'h1FFFFF, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'h41, 1'b0, 1'b1, 3'd4, 21'h000041, 1'b0},  // break with two held
    '{8'hE1, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'hC3, 1'b1, 1'b0, 3'd0, 21'h000000, 1'b0},  // break, final byte a lead
    '{8'hE1, 1'b0, 1'b0, 3'd0, 21'h000000, 1'b0},
    '{8'h80, 1'b1, 1'b0, 3'd0, 21'h000000, 1'b0},  // truncated at end of text
    '{8'hF5, 1'b1, 1'b1, 3'd1, 21'h000000, 1'b1},
    '{8'h41, 1'b1, 1'b1, 3'd1, 21'h000041, 1'b0}
  };

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] text_byte_i   = '0;
  logic             end_of_text_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i   = 1'b0;
  logic [CpW-1:0]   code_point_o;
  logic             invalid_o;
  logic             run_last_o;

  // decoder state mirror
  logic [CpW-1:0] dec_value  = '0;
  logic [1:0]     dec_needed = '0;
  logic [1:0]     dec_held   = '0;
  cp_result_t     decoded [4];
  int unsigned    decoded_n;

  cp_result_t  pending_cp_q [$];
  int unsigned err_cnt   = 0;
  int unsigned bytes_in  = 0;
  int unsigned eot_cnt   = 0;
  int unsigned rx_count  = 0;
  int unsigned inv_count = 0;
  bit          tx_burst  = 1'b0;
  bit          rx_burst  = 1'b0;
  bit          held_off  = 1'b0;

  utf8_stream_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .invalid_o     (invalid_o),
    .run_last_o    (run_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic add_decoded(input logic [CpW-1:0] cp, input logic inv);
    decoded[decoded_n] = '{cp, inv, 1'b0};
    decoded_n++;
  endtask

  task automatic clear_run();
    dec_value  = '0;
    dec_needed = '0;
    dec_held   = '0;
  endtask

  // one invalid zero for the lead and one per held continuation
  task automatic flush_run();
    add_decoded('0, 1'b1);
    for (int k = 0; k < dec_held; k++) add_decoded('0, 1'b1);
    clear_run();
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic eot);
    decoded_n = 0;
    if (dec_needed != 0 && (b & ContMask) == ContCode) begin
      dec_value  = (dec_value << 6) | CpW'(b & ContBits);
      dec_needed = dec_needed - 2'd1;
      dec_held   = dec_held + 2'd1;
      if (dec_needed == 0) begin
        add_decoded(dec_value, 1'b0);
        clear_run();
      end
    end else begin
      if (dec_needed != 0) flush_run();
      clear_run();
      if ((b & AsciiMask) == '0) begin
        add_decoded(CpW'(b), 1'b0);
      end else if ((b & Lead2Mask) == Lead2Code) begin
        dec_value  = CpW'(b & Lead2Bits);
        dec_needed = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        dec_value  = CpW'(b & Lead3Bits);
        dec_needed = 2'd2;
      end else if ((b & Lead4Mask) == Lead4Code) begin
        dec_value  = CpW'(b & Lead4Bits);
        dec_needed = 2'd3;
      end else begin
        add_decoded('0, 1'b1);
      end
    end
    if (eot && dec_needed != 0) flush_run();
    if (decoded_n > 0) decoded[decoded_n - 1].run_last = 1'b1;
  endtask

  task automatic queue_decoded();
    for (int k = 0; k < decoded_n; k++) pending_cp_q.push_back(decoded[k]);
  endtask

  // returns at the edge where the transaction is taken
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eot);
    int unsigned gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_in++;
    if (eot) eot_cnt++;
  endtask

  initial begin : stim_proc
    logic [ByteW-1:0] seq [4];
    int unsigned      seq_len;
    int unsigned      len;
    int unsigned      kind;
    logic             eot;
    cp_result_t       r;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      send_byte(DirTab[i].tbyte, DirTab[i].eot);
      decode_byte(DirTab[i].tbyte, DirTab[i].eot);
      if (DirTab[i].typed) begin
        for (int k = 0; k < DirTab[i].n; k++) begin
          if (k == DirTab[i].n - 1) r = '{DirTab[i].last_cp, DirTab[i].last_inv, 1'b1};
          else r = '{'0, 1'b1, 1'b0};
          pending_cp_q.push_back(r);
        end
      end else begin
        queue_decoded();
      end
    end

    // mostly well-formed characters, some cut short, some raw noise
    while (bytes_in < DirRows + RandItems) begin
      if ($urandom_range(0, 7) == 0) tx_burst = !tx_burst;
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      case (len)
        1: seq[0] = ByteW'($urandom_range(0, 127));
        2: seq[0] = Lead2Code | ByteW'($urandom_range(0, 31));
        3: seq[0] = Lead3Code | ByteW'($urandom_range(0, 15));
        default: seq[0] = Lead4Code | ByteW'($urandom_range(0, 7));
      endcase
      for (int k = 1; k < 4; k++) seq[k] = ContCode | ByteW'($urandom_range(0, 63));
      seq_len = len;
      if (kind == 8) seq_len = $urandom_range(1, len);
      if (kind == 9) begin
        seq_len = 1;
        seq[0]  = ByteW'($urandom_range(0, 255));
      end
      for (int k = 0; k < seq_len; k++) begin
        eot = (k == seq_len - 1) ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 31) == 0);
        send_byte(seq[k], eot);
        decode_byte(seq[k], eot);
        queue_decoded();
      end
    end
    in_valid_i <= 1'b0;

    while (pending_cp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d bytes (%0d with end of text), %0d results checked, %0d invalid",
             bytes_in, eot_cnt, rx_count, inv_count);
    $display("output held off for %0d cycles to back up the input, %0d mismatches",
             HoldCycles, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : rx_proc
    int unsigned stall;
    cp_result_t  got;
    cp_result_t  want;

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
      stall = draw_gap(rx_burst);
      // one long hold-off so the run queue fills and the input stalls
      if (rx_count == HoldAtCount && !held_off) begin
        stall    = stall + HoldCycles;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got = '{code_point_o, invalid_o, run_last_o};
      rx_count++;
      if (got.invalid) inv_count++;
      if (pending_cp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual cp=%h inv=%b last=%b",
                 $time, got.code_point, got.invalid, got.run_last);
      end else begin
        want = pending_cp_q.pop_front();
        if (got.code_point !== want.code_point) begin
          err_cnt++;
          $display("%0t: code_point mismatch, expected %h, actual %h",
                   $time, want.code_point, got.code_point);
        end
        if (got.invalid !== want.invalid) begin
          err_cnt++;
          $display("%0t: invalid mismatch, expected %b, actual %b",
                   $time, want.invalid, got.invalid);
        end
        if (got.run_last !== want.run_last) begin
          err_cnt++;
          $display("%0t: run_last mismatch, expected %b, actual %b",
                   $time, want.run_last, got.run_last);
        end
      end
    end
  end

endmodule

FILE: sim.f
hw/rtl/usd_pkg.sv
hw/rtl/usd_decode.sv
hw/rtl/utf8_stream_decoder.sv
test/utf8_stream_decoder_tb.sv
